// ===== sv/mpsm_pkg.sv =====
// Shared types and constants for the multi-pattern stream matcher.
`default_nettype none

package mpsm_pkg;

    // Fixed field widths of the register map and the stream words.
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int SEEN_W    = 4;
    localparam int COUNT_W   = 3;
    localparam int LENS_W    = 16;
    localparam int PAT_W     = 64;
    localparam int PAT_BYTES = 8;
    localparam int REG_SLOTS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 2;

    // Saturation point of the byte counter.
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTHS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_TWO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_THREE   = 3'd5;

    // Request and status codes.
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_END   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;
    localparam logic [LENS_W-1:0]  LENS_RESET  = 16'h1111;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [PAT_W-1:0]  pat_t;

endpackage

`default_nettype wire

// ===== sv/multi_pattern_stream_matcher_unit.sv =====
// Multi-pattern stream matcher: a row of window cells with a priority pick.
//
// Use: the input channel (in_valid/in_ready) carries one word per stream step:
// req_type selects a data byte (data_byte) or an end-of-stream mark. Each word
// gives exactly one result word on the output channel (out_valid/out_ready):
// status says no match yet, pattern matched (match_index is the lowest slot
// that matched) or stream ended without a match. A match or an end mark
// clears the byte count, so the next search starts afresh.
// Patterns are set through the configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) while no word is in flight; writes are taken at once.
// out_valid rises in the cycle after acceptance. Throughput is one word per cycle
// while the receiver keeps up: every cell compares its incoming byte with all slots
// in the cycle the word is taken, and a single output register holds the result.
// While the receiver stalls, the result word holds and in_ready drops until
// it is taken; a result taken in the same cycle frees room for a new word.
// After reset the block holds no result, the byte count is zero, one pattern
// of length one is in use and all pattern bytes are zero.
`default_nettype none

module multi_pattern_stream_matcher_unit #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            req_type,
    input  wire logic [mpsm_pkg::BYTE_W-1:0]     data_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [mpsm_pkg::STATUS_W-1:0]        status,
    output logic [mpsm_pkg::INDEX_W-1:0]         match_index,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mpsm_pkg::PAT_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [mpsm_pkg::COUNT_W-1:0] pattern_count_reg;
    logic [mpsm_pkg::LENS_W-1:0]  pattern_lengths_reg;
    mpsm_pkg::pat_t               pattern_reg [mpsm_pkg::REG_SLOTS];

    // Stream state and output register.
    logic [mpsm_pkg::SEEN_W-1:0]   seen_reg;
    logic [mpsm_pkg::SEEN_W-1:0]   seen_next;
    logic                          out_valid_reg;
    logic [mpsm_pkg::STATUS_W-1:0] status_reg;
    logic [mpsm_pkg::STATUS_W-1:0] status_next;
    logic [mpsm_pkg::INDEX_W-1:0]  match_index_reg;
    logic [mpsm_pkg::INDEX_W-1:0]  match_index_next;

    logic                          in_accept;
    logic                          shift_en;
    logic [mpsm_pkg::SEEN_W-1:0]   seen_inc;
    mpsm_pkg::len_t                slot_len [NUM_PATTERNS];
    mpsm_pkg::pat_t                slot_pat [NUM_PATTERNS];
    mpsm_pkg::byte_t               chain    [MAX_LEN+1];
    logic [NUM_PATTERNS-1:0]       cell_hit [MAX_LEN];
    logic [NUM_PATTERNS-1:0]       slot_match;
    logic                          found;
    logic [mpsm_pkg::INDEX_W-1:0]  found_idx;

    // Handshakes: room for a new word whenever the output register frees up.
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign shift_en  = in_accept && (req_type == mpsm_pkg::REQ_DATA);

    // Configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_count_reg   <= mpsm_pkg::COUNT_RESET;
            pattern_lengths_reg <= mpsm_pkg::LENS_RESET;
            for (int k = 0; k < mpsm_pkg::REG_SLOTS; k++)
            begin
                pattern_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mpsm_pkg::CFG_PATTERN_COUNT:
                    pattern_count_reg <= cfg_data[mpsm_pkg::COUNT_W-1:0];
                mpsm_pkg::CFG_PATTERN_LENGTHS:
                    pattern_lengths_reg <= cfg_data[mpsm_pkg::LENS_W-1:0];
                mpsm_pkg::CFG_PATTERN_ZERO:  pattern_reg[0] <= cfg_data;
                mpsm_pkg::CFG_PATTERN_ONE:   pattern_reg[1] <= cfg_data;
                mpsm_pkg::CFG_PATTERN_TWO:   pattern_reg[2] <= cfg_data;
                mpsm_pkg::CFG_PATTERN_THREE: pattern_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-slot length and bytes. Lengths saturate at the window depth;
    // slots without a register have length zero and zero bytes.
    genvar k;
    generate
        for (k = 0; k < NUM_PATTERNS; k++)
        begin : g_slot
            if (k < mpsm_pkg::REG_SLOTS)
            begin : g_reg
                logic [mpsm_pkg::LEN_W-1:0] raw_len;
                assign raw_len     = pattern_lengths_reg[mpsm_pkg::LEN_W*k +: mpsm_pkg::LEN_W];
                assign slot_len[k] = (32'(raw_len) > MAX_LEN) ? mpsm_pkg::LEN_W'(MAX_LEN)
                                                              : raw_len;
                assign slot_pat[k] = pattern_reg[k];
            end
            else
            begin : g_none
                assign slot_len[k] = '0;
                assign slot_pat[k] = '0;
            end
        end
    endgenerate

    // Row of window cells; the newest byte enters at cell zero.
    assign chain[0] = data_byte;

    genvar i;
    generate
        for (i = 0; i < MAX_LEN; i++)
        begin : g_cell
            mpsm_cell #(
                .CELL_IDX     (i),
                .NUM_PATTERNS (NUM_PATTERNS)
            ) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .byte_in  (chain[i]),
                .byte_out (chain[i+1]),
                .slot_len (slot_len),
                .slot_pat (slot_pat),
                .hit      (cell_hit[i])
            );
        end
    endgenerate

    // Count of bytes including the incoming one, saturating.
    assign seen_inc = (seen_reg == mpsm_pkg::SEEN_MAX) ? seen_reg
                                                       : seen_reg + mpsm_pkg::SEEN_W'(1);

    // A slot matches when it is in use, enough bytes are seen and no cell vetoes it.
    always_comb
    begin
        logic all_hit;
        all_hit = 1'b1;
        for (int s = 0; s < NUM_PATTERNS; s++)
        begin
            all_hit = 1'b1;
            for (int c = 0; c < MAX_LEN; c++)
            begin
                all_hit = all_hit && cell_hit[c][s];
            end
            slot_match[s] = all_hit && (s < int'(pattern_count_reg))
                         && (seen_inc >= slot_len[s]);
        end
    end

    // Lowest-indexed matching slot wins.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int s = NUM_PATTERNS - 1; s >= 0; s--)
        begin
            if (slot_match[s])
            begin
                found     = 1'b1;
                found_idx = mpsm_pkg::INDEX_W'(s);
            end
        end
    end

    // Result and next byte count of the word being taken.
    always_comb
    begin
        seen_next        = seen_reg;
        status_next      = status_reg;
        match_index_next = match_index_reg;
        if (in_accept)
        begin
            if (req_type == mpsm_pkg::REQ_END)
            begin
                seen_next        = '0;
                status_next      = mpsm_pkg::STATUS_END;
                match_index_next = '0;
            end
            else if (found)
            begin
                seen_next        = '0;
                status_next      = mpsm_pkg::STATUS_MATCH;
                match_index_next = found_idx;
            end
            else
            begin
                seen_next        = seen_inc;
                status_next      = mpsm_pkg::STATUS_NONE;
                match_index_next = '0;
            end
        end
    end

    // Byte count and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        match_index_reg <= match_index_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign match_index = match_index_reg;

endmodule

`default_nettype wire

// ===== sv/mpsm_cell.sv =====
// One window cell: holds a stream byte and checks it against every pattern slot.
`default_nettype none

module mpsm_cell #(
    parameter int CELL_IDX     = 0,
    parameter int NUM_PATTERNS = 4
) (
    input  wire logic                     clk,
    input  wire logic                     shift_en,
    input  wire mpsm_pkg::byte_t          byte_in,
    output logic [mpsm_pkg::BYTE_W-1:0]   byte_out,
    input  wire mpsm_pkg::len_t           slot_len [NUM_PATTERNS],
    input  wire mpsm_pkg::pat_t           slot_pat [NUM_PATTERNS],
    output logic [NUM_PATTERNS-1:0]       hit
);

    localparam mpsm_pkg::len_t POS = mpsm_pkg::LEN_W'(CELL_IDX);

    mpsm_pkg::byte_t byte_reg;

    // The byte moves one place older on every accepted data word.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // The incoming byte is what this cell will hold once the word is taken,
    // so it is compared here. A cell beyond a slot's length does not veto it.
    // Within the length, this cell faces pattern byte (length - 1 - position);
    // pattern bytes past the eighth read as zero.
    always_comb
    begin
        mpsm_pkg::len_t  pat_pos;
        mpsm_pkg::byte_t pat_byte;
        pat_pos  = '0;
        pat_byte = '0;
        for (int k = 0; k < NUM_PATTERNS; k++)
        begin
            pat_pos  = slot_len[k] - POS - mpsm_pkg::LEN_W'(1);
            pat_byte = pat_pos[mpsm_pkg::LEN_W-1] ? '0
                     : slot_pat[k][{pat_pos[mpsm_pkg::LEN_W-2:0], 3'b000} +: mpsm_pkg::BYTE_W];
            if (POS < slot_len[k])
            begin
                hit[k] = (byte_in == pat_byte);
            end
            else
            begin
                hit[k] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
